// ----- sv/jsse_pkg.sv -----
// jsse_pkg: payload types, microcode word, mode codes and the microcode ROM
// of the JTAG scan shift engine. No dependencies.
package jsse_pkg;

  typedef enum logic [1:0] {
    MODE_TMS   = 2'd0,
    MODE_SHIFT = 2'd1,
    MODE_PROG  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic {
    OP_WALK  = 1'b0,
    OP_SHIFT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    SRC_VALUE = 2'd0,
    SRC_CONST = 2'd1,
    SRC_INSTR = 2'd2,
    SRC_DR    = 2'd3
  } src_e;

  typedef enum logic [1:0] {
    CAP_NONE  = 2'd0,
    CAP_RAW   = 2'd1,
    CAP_REPLY = 2'd2
  } cap_e;

  localparam int unsigned MAX_PULSES = 32;
  localparam logic [5:0]  PATH_TO_IR     = 6'h0D;
  localparam logic [5:0]  PATH_TO_IR_LEN = 6'd6;
  localparam logic [5:0]  PATH_TO_DR     = 6'h03;
  localparam logic [5:0]  PATH_TO_DR_LEN = 6'd4;
  localparam logic [5:0]  IR_LEN         = 6'd4;
  localparam logic [5:0]  DR_LEN         = 6'd15;
  localparam int unsigned REPLY_BITS     = 15;
  localparam logic [3:0]  INSTR_RESET    = 4'h5;

  localparam logic [2:0]  PC_TMS   = 3'd0;
  localparam logic [2:0]  PC_SHIFT = 3'd1;
  localparam logic [2:0]  PC_PROG  = 3'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] value;
    logic [5:0]  count;
    logic [31:0] tdo_bits;
  } jsse_in_t;

  typedef struct packed {
    logic        tms;
    logic        tdi;
    logic        last;
    logic [31:0] captured;
  } jsse_out_t;

  // one microinstruction: repeats for len pulses (or the command count)
  typedef struct packed {
    op_e        op;
    src_e       src;
    logic       len_cnt;
    logic [5:0] len;
    logic [5:0] path;
    logic       endp;
    cap_e       cap;
  } ucode_t;

  // per-pulse control from sequencer to datapath
  typedef struct packed {
    op_e        op;
    src_e       src;
    logic [5:0] path;
    logic [4:0] bit_idx;
    logic       first;
    logic       last_bit;
    logic       last;
    cap_e       cap;
  } pulse_ctrl_t;

  function automatic logic [2:0] ucode_entry(input logic [1:0] mode);
    logic [2:0] pc;
    case (mode)
      MODE_TMS:   pc = PC_TMS;
      MODE_SHIFT: pc = PC_SHIFT;
      default:    pc = PC_PROG;
    endcase
    return pc;
  endfunction

  function automatic ucode_t ucode_rom(input logic [2:0] addr);
    ucode_t w;
    case (addr)
      3'd0: w = '{OP_WALK,  SRC_VALUE, 1'b1, 6'd0,           6'd0,       1'b1, CAP_NONE};
      3'd1: w = '{OP_SHIFT, SRC_VALUE, 1'b1, 6'd0,           6'd0,       1'b1, CAP_RAW};
      3'd2: w = '{OP_WALK,  SRC_CONST, 1'b0, PATH_TO_IR_LEN, PATH_TO_IR, 1'b0, CAP_NONE};
      3'd3: w = '{OP_SHIFT, SRC_INSTR, 1'b0, IR_LEN,         6'd0,       1'b0, CAP_NONE};
      3'd4: w = '{OP_WALK,  SRC_CONST, 1'b0, PATH_TO_DR_LEN, PATH_TO_DR, 1'b0, CAP_NONE};
      3'd5: w = '{OP_SHIFT, SRC_DR,    1'b0, DR_LEN,         6'd0,       1'b1, CAP_REPLY};
      default: w = '{OP_WALK, SRC_CONST, 1'b0, 6'd1,         6'd0,       1'b1, CAP_NONE};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/jsse_seq.sv -----
// jsse_seq: microcode sequencer - program counter, per-instruction bit
// counter and run state. Depends on jsse_pkg (ucode_rom, ucode_entry).
module jsse_seq
  import jsse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  mode,
  input  logic [5:0]  count,
  input  logic        advance,
  output logic        busy,
  output pulse_ctrl_t ctrl
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e     state_r, state_nxt;
  logic [2:0] pc_r, pc_nxt;
  logic [4:0] bit_r, bit_nxt;
  logic [5:0] count_r, count_nxt;
  ucode_t     uw;
  logic [5:0] len;
  logic       last_bit;

  assign uw       = ucode_rom(pc_r);
  assign len      = uw.len_cnt ? count_r : uw.len;
  assign last_bit = ({1'b0, bit_r} == len - 6'd1);
  assign busy     = (state_r == ST_RUN);

  always_comb begin
    ctrl.op       = uw.op;
    ctrl.src      = uw.src;
    ctrl.path     = uw.path;
    ctrl.bit_idx  = bit_r;
    ctrl.first    = (bit_r == 5'd0);
    ctrl.last_bit = last_bit;
    ctrl.last     = uw.endp & last_bit;
    ctrl.cap      = uw.cap;
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    bit_nxt   = bit_r;
    count_nxt = count_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          pc_nxt    = ucode_entry(mode);
          bit_nxt   = 5'd0;
          // saturate to the pulse limit
          count_nxt = (count > 6'(MAX_PULSES)) ? 6'(MAX_PULSES) : count;
        end
      end
      ST_RUN: begin
        if (advance) begin
          if (last_bit) begin
            bit_nxt = 5'd0;
            if (uw.endp) begin
              state_nxt = ST_IDLE;
            end else begin
              pc_nxt = pc_r + 3'd1;
            end
          end else begin
            bit_nxt = bit_r + 5'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= PC_TMS;
      bit_r   <= 5'd0;
      count_r <= 6'd0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      bit_r   <= bit_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- sv/jsse_dpath.sv -----
// jsse_dpath: scan datapath - command operands, TDI level, TDO sample and
// capture shift registers, per-pulse TMS/TDI/captured. Depends on jsse_pkg.
module jsse_dpath
  import jsse_pkg::*;
#(
  parameter int unsigned SHIFT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  jsse_in_t    item,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        advance,
  input  pulse_ctrl_t ctrl,
  output jsse_out_t   pulse
);

  localparam logic [SHIFT_WIDTH-1:0] TOP_BIT = {1'b1, {(SHIFT_WIDTH-1){1'b0}}};

  logic [31:0]            value_r;
  logic [31:0]            tdo_r, tdo_nxt;
  logic [3:0]             instr_r;
  logic                   tdi_lvl_r, tdi_lvl_nxt;
  logic [SHIFT_WIDTH-1:0] cap_r, cap_base, cap_nxt;
  logic [31:0]            src_word;
  logic                   src_bit;
  logic [63:0]            cap_ext;
  logic                   shift_now;

  always_comb begin
    case (ctrl.src)
      SRC_VALUE: src_word = value_r;
      SRC_CONST: src_word = 32'(ctrl.path);
      SRC_INSTR: src_word = 32'(instr_r);
      SRC_DR:    src_word = 32'(value_r[REPLY_BITS-1:0]);
      default:   src_word = 32'd0;
    endcase
  end

  assign src_bit   = src_word[ctrl.bit_idx];
  assign shift_now = advance && (ctrl.op == OP_SHIFT);

  // capture starts from zero at each shift instruction; sample enters the top
  assign cap_base = ctrl.first ? '0 : cap_r;
  assign cap_nxt  = (tdo_r[0] ? (cap_base | TOP_BIT) : cap_base) >> 1;
  assign cap_ext  = 64'(cap_nxt);

  assign tdo_nxt     = load ? item.tdo_bits : (shift_now ? (tdo_r >> 1) : tdo_r);
  assign tdi_lvl_nxt = shift_now ? src_bit : tdi_lvl_r;

  always_comb begin
    pulse.last = ctrl.last;
    if (ctrl.op == OP_SHIFT) begin
      pulse.tms = ctrl.last_bit;
      pulse.tdi = src_bit;
    end else begin
      pulse.tms = src_bit;
      pulse.tdi = tdi_lvl_r;
    end
    pulse.captured = 32'd0;
    if (ctrl.last) begin
      case (ctrl.cap)
        CAP_RAW:   pulse.captured = cap_ext[31:0];
        CAP_REPLY: pulse.captured = 32'(cap_nxt[SHIFT_WIDTH-2 -: REPLY_BITS]);
        default:   pulse.captured = 32'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      instr_r   <= INSTR_RESET;
      tdi_lvl_r <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        instr_r <= cfg_wr_data;
      end
      tdi_lvl_r <= tdi_lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= item.value;
    end
    tdo_r <= tdo_nxt;
    if (shift_now) begin
      cap_r <= cap_nxt;
    end
  end

endmodule

// ----- sv/jtag_scan_shift_engine_core.sv -----
// jtag_scan_shift_engine_core: top level of the JTAG master scan engine.
// Depends on jsse_pkg, jsse_seq and jsse_dpath.
//
//   channel  dir  handshake              payload
//   in_      in   in_valid / in_ready    jsse_in_t  (mode, value, count, tdo_bits)
//   out_     out  out_valid / out_ready  jsse_out_t (tms, tdi, last, captured)
//   cfg_     in   cfg_wr_en              cfg_wr_data (program_instruction)
//
// One TCK pulse result per clock while out_ready holds: count pulses for
// modes 0 and 1 (1..32), 29 for a programming command, once the command is
// accepted. The microcode sequencer steps one pulse per cycle and stalls on a
// full output register. A new command is taken as soon as the last pulse of
// the previous one is in the output register. Zero-count and mode 3 commands
// are accepted and produce nothing. Reset is synchronous, active low.
module jtag_scan_shift_engine_core
  import jsse_pkg::*;
#(
  parameter int unsigned SHIFT_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  jsse_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output jsse_out_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  logic        busy;
  logic        in_xfer;
  logic        cmd_ok;
  logic        start;
  logic        advance;
  pulse_ctrl_t ctrl;
  jsse_out_t   pulse;
  logic        out_valid_r, out_valid_nxt;
  jsse_out_t   out_data_r;

  assign in_ready = !busy;
  assign in_xfer  = in_valid && in_ready;
  assign cmd_ok   = (in_data.mode == MODE_PROG) ||
                    (((in_data.mode == MODE_TMS) || (in_data.mode == MODE_SHIFT)) &&
                     (in_data.count != 6'd0));
  assign start    = in_xfer && cmd_ok;
  assign advance  = busy && (!out_valid_r || out_ready);

  jsse_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .mode    (in_data.mode),
    .count   (in_data.count),
    .advance (advance),
    .busy    (busy),
    .ctrl    (ctrl)
  );

  jsse_dpath #(
    .SHIFT_WIDTH (SHIFT_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (in_xfer),
    .item        (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .ctrl        (ctrl),
    .pulse       (pulse)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= pulse;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_prog_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_data.mode == MODE_PROG)) |=> busy)
    else $error("programming command did not start the sequencer");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && pulse.last) |=> !busy)
    else $error("sequencer still busy after the last pulse");

  a_mid_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !pulse.last) |=> busy)
    else $error("sequencer stopped before the last pulse");

  a_cap_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.last) |-> (out_data_r.captured == 32'd0))
    else $error("captured word nonzero on a middle pulse");
`endif

endmodule
